// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Command codes, register map and phase table of the I2C bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Command codes carried on the input item
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_STOP    = 3'd1;
    localparam logic [2:0] CMD_TX_BYTE = 3'd2;
    localparam logic [2:0] CMD_RX_BYTE = 3'd3;
    localparam logic [2:0] CMD_TX_ACK  = 3'd4;
    localparam logic [2:0] CMD_RX_ACK  = 3'd5;

    // Register map
    localparam logic       REG_PHASE_TICKS   = 1'b0;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;

    // Position within a three-phase bit slot
    typedef logic [1:0] bit_step_t;
    localparam bit_step_t STEP_FIRST = 2'd0;
    localparam bit_step_t STEP_LAST  = 2'd2;

    typedef logic [4:0] phase_t;

    // Number of phases of each command
    function automatic phase_t phase_count(input logic [2:0] cmd);
        phase_t n;
        case (cmd)
            CMD_START:   n = 5'd4;
            CMD_STOP:    n = 5'd3;
            CMD_TX_BYTE: n = 5'd24;
            CMD_RX_BYTE: n = 5'd25;
            CMD_TX_ACK:  n = 5'd3;
            default:     n = 5'd4;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/i2c_master_bit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top
// Open-drain I2C master bit sequencer, one timer tick per input item.
// ----------------------------------------------------------------------------
// Each accepted input item is one timer tick and yields exactly one result
// item with the pin drives and status after that tick. An idle block takes a
// start, stop, send byte, receive byte, send ack or receive ack command and
// walks its pin phases, each held phase_ticks ticks (zero counts as one).
// Bytes move MSB first; SDA is sampled on the first tick of a read phase.
// A command offered while busy, or an unknown code, is dropped and flagged.
// One item is accepted per clock while the result side keeps up: the phase
// logic sits between the state registers and a single output register, so
// each result is registered and shown in the cycle after its item is taken.
module i2c_master_bit_sequencer_top #(
    parameter int TICK_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] ack_bit, [9] sda_in, rest zero
    input  logic [3:0]  s_tuser,   // [0] cmd_valid, [3:1] cmd
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                   // [3] done_res, [11:4] rx_byte, [12] ack_received,
                                   // [13] cmd_ignored, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    // Configuration register
    logic [15:0] phase_ticks_reg;

    // Sequencer state
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic [2:0]            active_reg, active_next;
    i2cm_pkg::phase_t      phase_reg, phase_next;
    i2cm_pkg::bit_step_t   step_reg, step_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next, tick_inc;
    logic                  busy_reg, busy_next;
    logic [7:0]            tx_reg, tx_next;
    logic [7:0]            rx_reg, rx_next;
    logic                  ack_reg, ack_next;
    logic                  ignored, done;

    // Output register
    logic                  out_valid_reg;
    logic [15:0]           out_data_reg;

    // Unpacked input fields
    logic        in_cmd_valid;
    logic [2:0]  in_cmd;
    logic [7:0]  in_tx_byte;
    logic        in_ack_bit;
    logic        in_sda;
    logic        s_accept;

    logic [LW-1:0] pt_ext, mask_ext, limit;

    assign in_cmd_valid = s_tuser[0];
    assign in_cmd       = s_tuser[3:1];
    assign in_tx_byte   = s_tdata[7:0];
    assign in_ack_bit   = s_tdata[8];
    assign in_sda       = s_tdata[9];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // APB register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == i2cm_pkg::REG_PHASE_TICKS) ? {16'd0, phase_ticks_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == i2cm_pkg::REG_PHASE_TICKS) begin
            phase_ticks_reg <= pwdata[15:0];
        end
    end

    // Clamp the hold time to one tick at least and to the counter range
    assign pt_ext   = LW'(phase_ticks_reg);
    assign mask_ext = LW'({TICK_WIDTH{1'b1}});
    always_comb begin
        if (pt_ext == '0) begin
            limit = LW'(1);
        end else if (pt_ext > mask_ext) begin
            limit = mask_ext;
        end else begin
            limit = pt_ext;
        end
    end

    // Next state and result for one tick
    always_comb begin
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        active_next = active_reg;
        phase_next  = phase_reg;
        step_next   = step_reg;
        tick_next   = tick_reg;
        busy_next   = busy_reg;
        tx_next     = tx_reg;
        rx_next     = rx_reg;
        ack_next    = ack_reg;
        ignored     = 1'b0;
        done        = 1'b0;
        tick_inc    = '0;

        // Take or drop a new command
        if (in_cmd_valid) begin
            if (busy_reg || in_cmd > i2cm_pkg::CMD_RX_ACK) begin
                ignored = 1'b1;
            end else begin
                active_next = in_cmd;
                phase_next  = '0;
                step_next   = i2cm_pkg::STEP_FIRST;
                tick_next   = '0;
                busy_next   = 1'b1;
                tx_next     = (in_cmd == i2cm_pkg::CMD_TX_ACK) ? {in_ack_bit, 7'd0}
                                                               : in_tx_byte;
            end
        end

        if (busy_next) begin
            // Act on the first tick of a phase
            if (tick_next == '0) begin
                case (active_next)
                    i2cm_pkg::CMD_START: begin
                        case (phase_next)
                            5'd0:    sda_next = 1'b1;
                            5'd1:    scl_next = 1'b1;
                            5'd2:    sda_next = 1'b0;
                            default: scl_next = 1'b0;
                        endcase
                    end
                    i2cm_pkg::CMD_STOP: begin
                        case (phase_next)
                            5'd0:    sda_next = 1'b0;
                            5'd1:    scl_next = 1'b1;
                            default: sda_next = 1'b1;
                        endcase
                    end
                    i2cm_pkg::CMD_TX_BYTE: begin
                        case (step_next)
                            2'd0:    sda_next = tx_next[7];
                            2'd1:    scl_next = 1'b1;
                            default: begin
                                scl_next = 1'b0;
                                tx_next  = {tx_next[6:0], 1'b0};
                            end
                        endcase
                    end
                    i2cm_pkg::CMD_RX_BYTE: begin
                        if (phase_next == '0) begin
                            sda_next = 1'b1;
                        end else begin
                            case (step_next)
                                2'd0:    scl_next = 1'b1;
                                2'd1:    rx_next  = {rx_next[6:0], in_sda};
                                default: scl_next = 1'b0;
                            endcase
                        end
                    end
                    i2cm_pkg::CMD_TX_ACK: begin
                        case (phase_next)
                            5'd0:    sda_next = tx_next[7];
                            5'd1:    scl_next = 1'b1;
                            default: scl_next = 1'b0;
                        endcase
                    end
                    default: begin
                        case (phase_next)
                            5'd0:    sda_next = 1'b1;
                            5'd1:    scl_next = 1'b1;
                            5'd2:    ack_next = in_sda;
                            default: scl_next = 1'b0;
                        endcase
                    end
                endcase
            end

            // Count the tick and advance the phase at the end of its hold
            tick_inc = tick_next + 1'b1;
            if (LW'(tick_inc) >= limit || tick_inc == '0) begin
                tick_next = '0;
                // receive byte starts its bit slots after the release phase
                if (!(active_next == i2cm_pkg::CMD_RX_BYTE && phase_next == '0)) begin
                    step_next = (step_next == i2cm_pkg::STEP_LAST) ? i2cm_pkg::STEP_FIRST
                                                                   : step_next + 1'b1;
                end
                phase_next = phase_next + 1'b1;
                if (phase_next >= i2cm_pkg::phase_count(active_next)) begin
                    busy_next  = 1'b0;
                    phase_next = '0;
                    done       = 1'b1;
                end
            end else begin
                tick_next = tick_inc;
            end
        end
    end

    // Commit state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            active_reg <= i2cm_pkg::CMD_START;
            phase_reg  <= '0;
            step_reg   <= i2cm_pkg::STEP_FIRST;
            tick_reg   <= '0;
            busy_reg   <= 1'b0;
            tx_reg     <= 8'd0;
            rx_reg     <= 8'd0;
            ack_reg    <= 1'b0;
        end else if (s_accept) begin
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            active_reg <= active_next;
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            tick_reg   <= tick_next;
            busy_reg   <= busy_next;
            tx_reg     <= tx_next;
            rx_reg     <= rx_next;
            ack_reg    <= ack_next;
        end
    end

    // Hold the result item until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_data_reg <= {2'b00, ignored, ack_next, rx_next, done, busy_next,
                             sda_next, scl_next};
        end
    end

    // A finished command never reports busy in the same item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy reported together");

    // A command offered while busy is flagged as dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_cmd_valid && busy_reg) |=> m_tdata[13])
        else $error("command while busy not flagged");

    // An idle sequencer sits at phase zero with a cleared tick counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> (phase_reg == '0 && tick_reg == '0))
        else $error("idle sequencer holds stale phase state");

    // A stalled result item keeps its contents
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result item changed");

endmodule

// ===== verif/i2c_master_bit_sequencer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_top_test
// Self-checking bench for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
// Every input item is one timer tick and gives one result item. A local
// model of the phase sequencer predicts the pin drives and status after each
// accepted tick; the result stream is compared field by field in order.
// A directed table covers reset, unknown and busy commands, every command,
// the tick register at zero, one and full scale, and a write to an unmapped
// address. Random ticks follow in phases with different phase lengths and
// idle patterns on both streams, including a long result-side stall.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_top_test;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_STALL       = 300;
    localparam int RANDOM_PER_PHASE = 72;
    localparam int END_PAD          = 8;

    // Codes outside the command set
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    // Register addresses
    localparam logic [2:0] ADDR_TICKS    = {i2cm_pkg::REG_PHASE_TICKS, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    // SDA source for the filler ticks of a table row
    localparam logic [1:0] SDA_LOW    = 2'd0;
    localparam logic [1:0] SDA_HIGH   = 2'd1;
    localparam logic [1:0] SDA_RANDOM = 2'd2;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_bit;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_rx;
        logic       ignored;
    } pin_result_t;

    typedef struct packed {
        bit          wr;
        logic [2:0]  wr_addr;
        logic [31:0] wr_value;
        tick_t       item;
        logic [7:0]  follow;
        logic [1:0]  follow_sda;
        bit          typed;
        pin_result_t result;
    } row_t;

    localparam pin_result_t RESULT_IDLE    = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam pin_result_t RESULT_DROPPED = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [7:0] tx_byte, [8] ack_bit, [9] sda_in, rest zero
    logic [3:0]  s_tuser  = '0;   // [0] cmd_valid, [3:1] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] scl_level, [1] sda_level, [2] busy_res,
                                  // [3] done_res, [11:4] rx_byte, [12] ack_received,
                                  // [13] cmd_ignored, rest zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_bit_sequencer_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Sequencer model state
    logic        scl_q, sda_q, busy_q, ack_q;
    logic [2:0]  cur_cmd;
    logic [4:0]  phase_idx;
    logic [15:0] tick_cnt, hold_ticks;
    logic [7:0]  tx_sr, rx_sr;

    pin_result_t pin_status_q [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          stall_asks     = 0;
    int          stall_seen     = 0;
    int          stall_left     = 0;

    // Directed table: register write, lead item, filler ticks, typed result
    row_t plan [24] = '{
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b0, i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0},
          8'd0, SDA_RANDOM, 1'b1, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, CMD_BAD_HI, 8'hFF, 1'b1, 1'b1},
          8'd0, SDA_RANDOM, 1'b1, RESULT_DROPPED},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, CMD_BAD_LO, 8'h00, 1'b0, 1'b0},
          8'd0, SDA_RANDOM, 1'b1, RESULT_DROPPED},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b0, i2cm_pkg::CMD_RX_ACK, 8'hAA, 1'b1, 1'b1},
          8'd0, SDA_RANDOM, 1'b1, RESULT_IDLE},
        '{1'b1, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_START, 8'h3C, 1'b0, 1'b1},
          8'd5, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_TX_BYTE, 8'hA5, 1'b0, 1'b0},
          8'd25, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_TX_BYTE, 8'hFF, 1'b1, 1'b1},
          8'd3, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0},
          8'd22, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_TX_BYTE, 8'h00, 1'b0, 1'b0},
          8'd25, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 1'b1},
          8'd26, SDA_HIGH, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_RX_BYTE, 8'hFF, 1'b1, 1'b0},
          8'd26, SDA_LOW, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_RX_BYTE, 8'h81, 1'b0, 1'b1},
          8'd26, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_TX_ACK, 8'hFF, 1'b0, 1'b1},
          8'd4, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_TX_ACK, 8'h00, 1'b1, 1'b0},
          8'd4, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_RX_ACK, 8'h00, 1'b0, 1'b1},
          8'd5, SDA_HIGH, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_RX_ACK, 8'hFF, 1'b1, 1'b0},
          8'd5, SDA_LOW, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0},
          8'd4, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b1, ADDR_TICKS, 32'd1, '{1'b1, i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0},
          8'd10, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b1, ADDR_TICKS, 32'd3, '{1'b1, i2cm_pkg::CMD_TX_BYTE, 8'h5A, 1'b0, 1'b0},
          8'd80, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b1, ADDR_TICKS, 32'hA5A5_FFFF, '{1'b1, i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0},
          8'd40, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b0, ADDR_TICKS, 32'd0, '{1'b1, i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0},
          8'd5, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b1, ADDR_TICKS, 32'd1, '{1'b0, i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0},
          8'd10, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b1, ADDR_UNMAPPED, 32'd7, '{1'b1, i2cm_pkg::CMD_RX_ACK, 8'h00, 1'b0, 1'b1},
          8'd8, SDA_RANDOM, 1'b0, RESULT_IDLE},
        '{1'b1, ADDR_TICKS, 32'h0001_0002, '{1'b1, i2cm_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 1'b0},
          8'd60, SDA_RANDOM, 1'b0, RESULT_IDLE}
    };

    // Advance the sequencer model by one tick and return the pins and status
    function automatic pin_result_t advance_sequencer(input tick_t t);
        pin_result_t r;
        int          p;
        int          k;
        logic [15:0] hold;
        logic [4:0]  phase_total;
        r.ignored = 1'b0;
        r.done    = 1'b0;
        if (t.cmd_valid) begin
            if (busy_q || t.cmd > i2cm_pkg::CMD_RX_ACK) begin
                r.ignored = 1'b1;
            end else begin
                cur_cmd   = t.cmd;
                phase_idx = '0;
                tick_cnt  = '0;
                busy_q    = 1'b1;
                tx_sr     = (t.cmd == i2cm_pkg::CMD_TX_ACK) ? {t.ack_bit, 7'b0} : t.tx_byte;
            end
        end
        if (busy_q) begin
            hold = (hold_ticks == 16'd0) ? 16'd1 : hold_ticks;
            p    = phase_idx;
            // act on the first tick of a phase
            if (tick_cnt == 16'd0) begin
                case (cur_cmd)
                    i2cm_pkg::CMD_START: begin
                        if (p == 0) sda_q = 1'b1;
                        else if (p == 1) scl_q = 1'b1;
                        else if (p == 2) sda_q = 1'b0;
                        else scl_q = 1'b0;
                    end
                    i2cm_pkg::CMD_STOP: begin
                        if (p == 0) sda_q = 1'b0;
                        else if (p == 1) scl_q = 1'b1;
                        else sda_q = 1'b1;
                    end
                    i2cm_pkg::CMD_TX_BYTE: begin
                        k = p % 3;
                        if (k == 0) sda_q = tx_sr[7];
                        else if (k == 1) scl_q = 1'b1;
                        else begin
                            scl_q = 1'b0;
                            tx_sr = {tx_sr[6:0], 1'b0};
                        end
                    end
                    i2cm_pkg::CMD_RX_BYTE: begin
                        k = (p - 1) % 3;
                        if (p == 0) sda_q = 1'b1;
                        else if (k == 0) scl_q = 1'b1;
                        else if (k == 1) rx_sr = {rx_sr[6:0], t.sda_in};
                        else scl_q = 1'b0;
                    end
                    i2cm_pkg::CMD_TX_ACK: begin
                        if (p == 0) sda_q = tx_sr[7];
                        else if (p == 1) scl_q = 1'b1;
                        else scl_q = 1'b0;
                    end
                    default: begin
                        if (p == 0) sda_q = 1'b1;
                        else if (p == 1) scl_q = 1'b1;
                        else if (p == 2) ack_q = t.sda_in;
                        else scl_q = 1'b0;
                    end
                endcase
            end
            case (cur_cmd)
                i2cm_pkg::CMD_START:   phase_total = 5'd4;
                i2cm_pkg::CMD_STOP:    phase_total = 5'd3;
                i2cm_pkg::CMD_TX_BYTE: phase_total = 5'd24;
                i2cm_pkg::CMD_RX_BYTE: phase_total = 5'd25;
                i2cm_pkg::CMD_TX_ACK:  phase_total = 5'd3;
                default:               phase_total = 5'd4;
            endcase
            // count the tick, close the phase at the hold length or on wrap
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= hold || tick_cnt == 16'd0) begin
                tick_cnt  = '0;
                phase_idx = phase_idx + 5'd1;
                if (phase_idx >= phase_total) begin
                    busy_q    = 1'b0;
                    phase_idx = '0;
                    r.done    = 1'b1;
                end
            end
        end
        r.scl     = scl_q;
        r.sda     = sda_q;
        r.busy    = busy_q;
        r.rx_byte = rx_sr;
        r.ack_rx  = ack_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offer one tick, wait for acceptance, queue its expected result
    task automatic offer_tick(input tick_t t, input bit typed, input pin_result_t want);
        pin_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, t.sda_in, t.ack_bit, t.tx_byte};
        s_tuser  <= {t.cmd, t.cmd_valid};
        do @(posedge aclk); while (!s_tready);
        r = advance_sequencer(t);
        pin_status_q.push_back(typed ? want : r);
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pin_status_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the tick register with the stream quiet, then read it back
    task automatic program_ticks(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] rd;
        drain_results();
        apb_access(1'b1, addr, value, rd);
        if (addr[2] == i2cm_pkg::REG_PHASE_TICKS && addr[1:0] == 2'b00) begin
            hold_ticks = value[15:0];
        end
        // leave the bus idle between the two transfers
        @(posedge aclk);
        apb_access(1'b0, ADDR_TICKS, 32'd0, rd);
        check_field("phase_ticks", {16'h0, hold_ticks}, rd);
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        pin_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pin_status_q.size() == 0) begin
                $error("result item %0h with no expectation waiting", m_tdata);
                mismatch_count++;
            end else begin
                want = pin_status_q.pop_front();
                check_field("scl_level", want.scl, m_tdata[0]);
                check_field("sda_level", want.sda, m_tdata[1]);
                check_field("busy_res", want.busy, m_tdata[2]);
                check_field("done_res", want.done, m_tdata[3]);
                check_field("rx_byte", want.rx_byte, m_tdata[11:4]);
                check_field("ack_received", want.ack_rx, m_tdata[12]);
                check_field("cmd_ignored", want.ignored, m_tdata[13]);
            end
        end
    end

    // Result-side ready: random idling, or a long hold-off on request
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_seen != stall_asks) begin
            m_tready   <= 1'b0;
            stall_seen <= stall_asks;
            stall_left <= LONG_STALL;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        tick_t t;
        int    phase;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        busy_q     = 1'b0;
        ack_q      = 1'b0;
        cur_cmd    = i2cm_pkg::CMD_START;
        phase_idx  = '0;
        tick_cnt   = '0;
        hold_ticks = i2cm_pkg::PHASE_TICKS_RESET;
        tx_sr      = '0;
        rx_sr      = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        send_idle_pct = 23;
        recv_idle_pct <= 76;
        foreach (plan[i]) begin
            if (plan[i].wr) program_ticks(plan[i].wr_addr, plan[i].wr_value);
            offer_tick(plan[i].item, plan[i].typed, plan[i].result);
            repeat (plan[i].follow) begin
                t.cmd_valid = 1'b0;
                t.cmd       = 3'($urandom_range(0, 7));
                t.tx_byte   = 8'($urandom_range(0, 255));
                t.ack_bit   = 1'($urandom_range(0, 1));
                t.sda_in    = (plan[i].follow_sda == SDA_RANDOM) ?
                              1'($urandom_range(0, 1)) : plan[i].follow_sda[0];
                offer_tick(t, 1'b0, RESULT_IDLE);
            end
        end

        // Random ticks: mostly real commands when idle, rare drops when busy
        for (phase = 0; phase < 6; phase++) begin
            program_ticks(ADDR_TICKS, {16'($urandom), 16'($urandom_range(0, 4))});
            send_idle_pct = (phase % 3 == 0) ? 23 : (phase % 3 == 1) ? 76 : 0;
            recv_idle_pct <= (phase % 3 == 0) ? 76 : (phase % 3 == 1) ? 23 : 0;
            if (phase == 2) stall_asks <= stall_asks + 1;
            repeat (RANDOM_PER_PHASE) begin
                if (!busy_q) begin
                    t.cmd_valid = ($urandom_range(0, 99) < 60);
                    t.cmd = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(6, 7)) :
                                                          3'($urandom_range(0, 5));
                end else begin
                    t.cmd_valid = ($urandom_range(0, 99) < 4);
                    t.cmd       = 3'($urandom_range(0, 7));
                end
                t.tx_byte = 8'($urandom_range(0, 255));
                t.ack_bit = 1'($urandom_range(0, 1));
                t.sda_in  = 1'($urandom_range(0, 1));
                offer_tick(t, 1'b0, RESULT_IDLE);
            end
        end

        // Wind down
        drain_results();
        repeat (END_PAD) @(posedge aclk);
        if (pin_status_q.size() != 0) begin
            $error("%0d expected result items never arrived", pin_status_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/i2cm_pkg.sv
rtl/i2c_master_bit_sequencer_top.sv
verif/i2c_master_bit_sequencer_top_test.sv
